// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/mwva_pkg.sv -----
// Package with the types, codes and cell record of the VM ALU.
package mwva_pkg;
  typedef enum logic [3:0] {
    K_ASSIGN = 4'd0, K_ADD = 4'd1, K_SUB = 4'd2, K_MUL = 4'd3, K_SHL = 4'd4,
    K_SHR = 4'd5, K_AND = 4'd6, K_OR = 4'd7, K_DIV = 4'd8, K_MOD = 4'd9
  } kind_t;

  localparam logic [2:0] F_BYTE = 3'd0;
  localparam logic [2:0] F_WORD = 3'd1;
  localparam logic [2:0] F_DWORD = 3'd2;
  localparam logic [2:0] F_ADDR = 3'd3;
  localparam logic [2:0] F_STR = 3'd4;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_WIDTH = 2'd1;
  localparam logic [1:0] ERR_DIV0 = 2'd2;

  localparam int unsigned DivBits = 32;

  typedef struct packed {
    logic        is_div;
    logic        is_mod;
    logic        neg_q;
    logic        neg_r;
    logic [1:0]  wsel;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
    logic [31:0] value;
    logic [1:0]  form;
    logic [15:0] seg;
    logic [15:0] off;
    logic [1:0]  err;
  } cell_t;

  function automatic logic [31:0] wmask(input logic [1:0] w);
    logic [31:0] m;
    case (w)
      2'd0: m = 32'h0000_00FF;
      2'd1: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction
endpackage

// ----- rtl/mwva_front.sv -----
// Decode stage: computes every operation but divide and modulo and sets up both.
module mwva_front (
  input  logic [3:0]           kind,
  input  logic [2:0]           width_form,
  input  logic                 first_is_address,
  input  logic                 second_is_address,
  input  logic                 first_is_signed,
  input  logic                 second_is_signed,
  input  logic [31:0]          operand_one,
  input  logic [31:0]          operand_two,
  input  logic [15:0]          addr_one_segment,
  input  logic [15:0]          addr_one_offset,
  input  logic [15:0]          addr_two_segment,
  input  logic [15:0]          addr_two_offset,
  output mwva_pkg::cell_t      item
);
  import mwva_pkg::*;

  logic [1:0]  w;
  logic [31:0] m, x, y, sx, sy, ax, ay, shr_v;
  logic [5:0]  bits;
  logic        big, neg, sgn;
  logic [15:0] delta, boff;
  logic [63:0] prod;

  always_comb begin
    w = (width_form == F_WORD) ? 2'd1 : (width_form == F_DWORD) ? 2'd2 : 2'd0;
    m = wmask(w);
    bits = (w == 2'd0) ? 6'd8 : (w == 2'd1) ? 6'd16 : 6'd32;
    x = operand_one & m;
    y = operand_two & m;
    big = (y >= {26'd0, bits});
    case (w)
      2'd0: begin
        sx = {{24{x[7]}}, x[7:0]};
        sy = {{24{y[7]}}, y[7:0]};
      end
      2'd1: begin
        sx = {{16{x[15]}}, x[15:0]};
        sy = {{16{y[15]}}, y[15:0]};
      end
      default: begin
        sx = x;
        sy = y;
      end
    endcase
    neg = first_is_signed & sx[31];
    sgn = first_is_signed | second_is_signed;
    ax = (sgn && sx[31]) ? (32'd0 - sx) : x;
    ay = (sgn && sy[31]) ? (32'd0 - sy) : y;
    shr_v = big ? (neg ? m : 32'd0) : (neg ? (~((~x & m) >> y[4:0]) & m) : (x >> y[4:0]));
    prod = {32'd0, x} * {32'd0, y};
    delta = first_is_address ? y[15:0] : x[15:0];
    boff = first_is_address ? addr_one_offset : addr_two_offset;

    item = '0;
    item.wsel = w;
    if (kind > 4'd9) begin
      item = '0;
    end else if (width_form > F_STR) begin
      item.err = ERR_WIDTH;
    end else if (kind == K_ASSIGN) begin
      if (width_form >= F_ADDR) begin
        item.form = 2'd3;
        item.seg = addr_one_segment;
        item.off = addr_one_offset;
      end else begin
        item.form = w;
        item.value = x;
      end
    end else if (width_form >= F_ADDR) begin
      item.err = ERR_WIDTH;
    end else if ((kind == K_ADD || kind == K_SUB) && (first_is_address || second_is_address)) begin
      item.form = 2'd3;
      item.seg = first_is_address ? addr_one_segment : addr_two_segment;
      item.off = (kind == K_ADD) ? boff + delta : boff - delta;
    end else begin
      item.form = w;
      case (kind)
        K_ADD: item.value = (x + y) & m;
        K_SUB: item.value = (x - y) & m;
        K_MUL: item.value = prod[31:0] & m;
        K_SHL: item.value = big ? 32'd0 : ((x << y[4:0]) & m);
        K_SHR: item.value = shr_v;
        K_AND: item.value = x & y;
        K_OR: item.value = x | y;
        default: begin
          if (y == 32'd0) begin
            item.err = ERR_DIV0;
            item.form = 2'd0;
          end else begin
            item.is_div = (kind == K_DIV);
            item.is_mod = (kind == K_MOD);
            item.neg_q = sgn & (sx[31] ^ sy[31]);
            item.neg_r = sgn & sx[31];
            item.quo = ax;
            item.dvs = ay;
          end
        end
      endcase
    end
  end
endmodule

// ----- rtl/mwva_cell.sv -----
// One restoring-divide cell: retires one quotient bit and passes the item on.
module mwva_cell (
  input  logic            clk,
  input  logic            en,
  input  mwva_pkg::cell_t din,
  output mwva_pkg::cell_t dout
);
  import mwva_pkg::*;

  logic [32:0] trial;
  logic [31:0] r_sh;
  cell_t       nxt;

  always_comb begin
    nxt = din;
    r_sh = {din.rem[30:0], din.quo[31]};
    trial = {1'b0, r_sh} - {1'b0, din.dvs};
    if (din.is_div || din.is_mod) begin
      if (din.rem[31] || !trial[32]) begin
        nxt.rem = trial[31:0];
        nxt.quo = {din.quo[30:0], 1'b1};
      end else begin
        nxt.rem = r_sh;
        nxt.quo = {din.quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule

// ----- rtl/mwva_back.sv -----
// Final step: applies signs, wraps the quotient or remainder to width, and passes other results through.
module mwva_back (
  input  mwva_pkg::cell_t din,
  output logic [31:0]     value
);
  import mwva_pkg::*;

  logic [31:0] q, r;

  always_comb begin
    q = din.neg_q ? (32'd0 - din.quo) : din.quo;
    r = din.neg_r ? (32'd0 - din.rem) : din.rem;
    if (din.is_div) begin
      value = q & wmask(din.wsel);
    end else if (din.is_mod) begin
      value = r & wmask(din.wsel);
    end else begin
      value = din.value;
    end
  end
endmodule

// ----- rtl/multi_width_vm_alu_unit.sv -----
// Top level of the pipelined multi-width VM ALU.
// The input channel takes one instruction beat per cycle on valid and ready;
// the output channel gives one result beat per instruction, in order.
// Every instruction passes a decode stage and then a chain of 32 divide
// cells, one quotient bit per cell, for every operation, and throughput
// is one beat per cycle while the receiver takes each result beat.
// The chain moves only when its last stage is empty or is being taken,
// so a stalled receiver freezes the whole chain and in_ready falls until
// the result beat is accepted; no beat is lost or repeated.
// The error code reports invalid widths and divide by zero; on an error
// every other result field is zero.
// Reset empties the chain by clearing the valid bit of every stage; the
// payload registers are not reset.
// Nothing needs configuring.
module multi_width_vm_alu_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  kind,
  input  logic [2:0]  width_form,
  input  logic        first_is_address,
  input  logic        second_is_address,
  input  logic        first_is_signed,
  input  logic        second_is_signed,
  input  logic [31:0] operand_one,
  input  logic [31:0] operand_two,
  input  logic [15:0] addr_one_segment,
  input  logic [15:0] addr_one_offset,
  input  logic [15:0] addr_two_segment,
  input  logic [15:0] addr_two_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_value,
  output logic [1:0]  result_form,
  output logic [15:0] result_segment,
  output logic [15:0] result_offset,
  output logic [1:0]  error_code
);
  import mwva_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned Depth = DivBits + 1;

  cell_t             front_cell;
  cell_t             stage [Depth];
  logic [Depth-1:0]  vld;
  logic              adv;

  assign adv = !vld[Depth-1] || out_ready;
  assign in_ready = adv;

  mwva_front u_front (
    .kind(kind), .width_form(width_form),
    .first_is_address(first_is_address), .second_is_address(second_is_address),
    .first_is_signed(first_is_signed), .second_is_signed(second_is_signed),
    .operand_one(operand_one), .operand_two(operand_two),
    .addr_one_segment(addr_one_segment), .addr_one_offset(addr_one_offset),
    .addr_two_segment(addr_two_segment), .addr_two_offset(addr_two_offset),
    .item(front_cell)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      stage[0] <= front_cell;
    end
  end

  for (genvar i = 0; i < DivBits; i++) begin : g_cell
    mwva_cell u_cell (.clk(clk), .en(adv), .din(stage[i]), .dout(stage[i+1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  mwva_back u_back (.din(stage[Depth-1]), .value(result_value));

  assign out_valid = vld[Depth-1];
  assign result_form = stage[Depth-1].form;
  assign result_segment = stage[Depth-1].seg;
  assign result_offset = stage[Depth-1].off;
  assign error_code = stage[Depth-1].err;

  `ASSERT_IMPL(a_stall_blocks, clk, rst, out_valid && !out_ready, !in_ready)
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_IMPL(a_err_clean, clk, rst, out_valid && error_code != ERR_NONE,
    result_value == 32'd0 && result_segment == 16'd0)
endmodule
